// ----- rtl/dbba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the disk block bitmap allocator.
// No dependencies; the other files, apart from dbba_ram, refer to it by scoped names.
package dbba_pkg;

    localparam int BLK_W = 6;
    localparam int CNT_W = 7;

    localparam logic [2:0] OP_CONT   = 3'd0;
    localparam logic [2:0] OP_IBEGIN = 3'd1;
    localparam logic [2:0] OP_IDATA  = 3'd2;
    localparam logic [2:0] OP_LINK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // Most blocks a linked request may claim (one beat per block).
    localparam logic [CNT_W-1:0] MAX_EMIT = 7'd64;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXCEEDS = 3'd1,
        ST_TAKEN   = 3'd2,
        ST_FEW     = 3'd3,
        ST_INDEX   = 3'd4,
        ST_PENDING = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [BLK_W-1:0] block;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_in;

    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] block_number;
        logic [BLK_W-1:0] end_block;
        logic             last_result;
    } t_out;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_DROP_RD,
        S_DROP_WR,
        S_COMMIT_RD,
        S_COMMIT_WR,
        S_IDX,
        S_IDX_RD,
        S_IDX_CHK,
        S_DATA_RD,
        S_DATA_CHK,
        S_CC_RD,
        S_CC_CHK,
        S_CM_RD,
        S_CM_WR,
        S_LS_RD,
        S_LS_CHK,
        S_LC_RD,
        S_LC_CHK,
        S_LA_RD,
        S_LA_CHK
    } t_state;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_BLK,
        ADDR_INC
    } t_addr_op;

    // Map entry is {pending, allocated}.
    typedef enum logic [2:0] {
        WR_CLEAR,
        WR_SET_PEND,
        WR_SET_ALLOC,
        WR_DROP,
        WR_COMMIT
    } t_wr_mode;

    typedef enum logic [2:0] {
        FLG_NONE,
        FLG_CLEAR,
        FLG_BEGIN_FAIL,
        FLG_BEGIN_OK,
        FLG_FAIL
    } t_flag_op;

    typedef enum logic [1:0] {
        BN_BLK,
        BN_ADDR,
        BN_ZERO
    } t_bn_sel;

    typedef enum logic [1:0] {
        END_ZERO,
        END_BLK,
        END_CEND
    } t_end_sel;

    typedef struct packed {
        logic     load;
        t_addr_op addr_op;
        logic     rd;
        logic     wr;
        t_wr_mode wr_mode;
        t_flag_op flag_op;
        logic     found_clr;
        logic     found_inc;
        logic     emit;
        t_status  emit_status;
        t_bn_sel  bn_sel;
        t_end_sel end_sel;
        logic     emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       last;
        logic       blk_oob;
        logic       cnt_zero;
        logic       cont_exceeds;
        logic       link_exceeds;
        logic       open;
        logic       failed;
        logic       dirty;
        logic       rd_alloc;
        logic       scan_end;
        logic       cont_end;
        logic       found_hit;
        logic       out_free;
    } t_dp_sts;

endpackage

// ----- rtl/dbba_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module dbba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/dbba_dp.sv -----
`timescale 1ns / 1ps
// Datapath: item register, scan address and found counters, batch flags,
// block map RAM and output register. Uses dbba_pkg and dbba_ram.
module dbba_dp #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dbba_pkg::t_in   i_in_data,
    input  dbba_pkg::t_dp_cmd i_cmd,
    output dbba_pkg::t_dp_sts o_sts,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output dbba_pkg::t_out  o_out_data
);
    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    dbba_pkg::t_in  r_item;
    dbba_pkg::t_out r_out;
    dbba_pkg::t_out n_out;
    logic [AW-1:0]  r_addr, n_addr;
    logic [dbba_pkg::CNT_W-1:0] r_found, n_found;
    logic           r_open, n_open;
    logic           r_failed, n_failed;
    logic           r_dirty, n_dirty;
    logic           r_out_valid, n_out_valid;

    logic [1:0]     w_rd_data;
    logic [1:0]     w_wr_data;
    logic           w_rd_alloc;
    logic           w_rd_pend;
    logic [dbba_pkg::CNT_W-1:0] w_cend;

    dbba_ram #(
        .WIDTH (2),
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_alloc = w_rd_data[0];
    assign w_rd_pend  = w_rd_data[1];
    assign w_cend     = dbba_pkg::CNT_W'(r_item.block) + r_item.count - 7'd1;

    always_comb begin
        case (i_cmd.wr_mode)
            dbba_pkg::WR_CLEAR:     w_wr_data = 2'b00;
            dbba_pkg::WR_SET_PEND:  w_wr_data = {1'b1, w_rd_alloc};
            dbba_pkg::WR_SET_ALLOC: w_wr_data = {w_rd_pend, 1'b1};
            dbba_pkg::WR_DROP:      w_wr_data = {1'b0, w_rd_alloc};
            dbba_pkg::WR_COMMIT:    w_wr_data = {1'b0, w_rd_alloc | w_rd_pend};
            default:                w_wr_data = 2'b00;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_sts.op           = r_item.opcode;
        o_sts.last         = r_item.last;
        o_sts.blk_oob      = 32'(r_item.block) >= 32'(NUM_BLOCKS);
        o_sts.cnt_zero     = (r_item.count == '0);
        o_sts.cont_exceeds = (32'(r_item.block) + 32'(r_item.count)) > 32'(NUM_BLOCKS);
        o_sts.link_exceeds = (32'(r_item.block) >= 32'(NUM_BLOCKS))
                             || (r_item.count > dbba_pkg::MAX_EMIT);
        o_sts.open         = r_open;
        o_sts.failed       = r_failed;
        o_sts.dirty        = r_dirty;
        o_sts.rd_alloc     = w_rd_alloc;
        o_sts.scan_end     = 32'(r_addr) == 32'(NUM_BLOCKS - 1);
        o_sts.cont_end     = 32'(r_addr) == 32'(w_cend);
        o_sts.found_hit    = (r_found + 7'd1) == r_item.count;
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_addr = r_addr;
        case (i_cmd.addr_op)
            dbba_pkg::ADDR_HOLD: n_addr = r_addr;
            dbba_pkg::ADDR_ZERO: n_addr = '0;
            dbba_pkg::ADDR_BLK:  n_addr = AW'(r_item.block);
            dbba_pkg::ADDR_INC:  n_addr = r_addr + 1'b1;
            default:             n_addr = r_addr;
        endcase

        n_found = r_found;
        if (i_cmd.found_clr) begin
            n_found = '0;
        end else if (i_cmd.found_inc) begin
            n_found = r_found + 7'd1;
        end

        n_open   = r_open;
        n_failed = r_failed;
        n_dirty  = r_dirty;
        if (i_cmd.wr && (i_cmd.wr_mode == dbba_pkg::WR_SET_PEND)) begin
            n_dirty = 1'b1;
        end
        case (i_cmd.flag_op)
            dbba_pkg::FLG_NONE: begin
            end
            dbba_pkg::FLG_CLEAR: begin
                n_open   = 1'b0;
                n_failed = 1'b0;
                n_dirty  = 1'b0;
            end
            dbba_pkg::FLG_BEGIN_FAIL: begin
                n_open   = !r_item.last;
                n_failed = !r_item.last;
            end
            dbba_pkg::FLG_BEGIN_OK: begin
                n_open   = 1'b1;
                n_failed = 1'b0;
            end
            dbba_pkg::FLG_FAIL: begin
                n_failed = 1'b1;
            end
            default: begin
            end
        endcase

        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        n_out.status      = i_cmd.emit_status;
        n_out.last_result = i_cmd.emit_last;
        case (i_cmd.bn_sel)
            dbba_pkg::BN_BLK:  n_out.block_number = r_item.block;
            dbba_pkg::BN_ADDR: n_out.block_number = dbba_pkg::BLK_W'(r_addr);
            dbba_pkg::BN_ZERO: n_out.block_number = '0;
            default:           n_out.block_number = '0;
        endcase
        case (i_cmd.end_sel)
            dbba_pkg::END_ZERO: n_out.end_block = '0;
            dbba_pkg::END_BLK:  n_out.end_block = r_item.block;
            dbba_pkg::END_CEND: n_out.end_block = dbba_pkg::BLK_W'(w_cend);
            default:            n_out.end_block = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_found     <= '0;
            r_open      <= 1'b0;
            r_failed    <= 1'b0;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_addr      <= n_addr;
            r_found     <= n_found;
            r_open      <= n_open;
            r_failed    <= n_failed;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/dbba_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences map reads, writes, sweeps and beats.
// Uses dbba_pkg; drives the datapath only through t_dp_cmd.
module dbba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dbba_pkg::t_dp_sts i_sts,
    output dbba_pkg::t_dp_cmd o_cmd
);
    dbba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbba_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.emit_last  = 1'b1;

        case (r_state)
            // Write every entry free; used after reset and by the clear opcode.
            dbba_pkg::S_CLR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_mode = dbba_pkg::WR_CLEAR;
                if (i_sts.scan_end) begin
                    o_cmd.flag_op = dbba_pkg::FLG_CLEAR;
                    n_state       = dbba_pkg::S_IDLE;
                end else begin
                    o_cmd.addr_op = dbba_pkg::ADDR_INC;
                end
            end

            dbba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dbba_pkg::S_DEC;
                end
            end

            dbba_pkg::S_DEC: begin
                case (i_sts.op)
                    dbba_pkg::OP_CONT: begin
                        if (i_sts.cont_exceeds) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = dbba_pkg::ST_EXCEEDS;
                                n_state           = dbba_pkg::S_IDLE;
                            end
                        end else if (i_sts.cnt_zero) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = dbba_pkg::ST_OK;
                                o_cmd.end_sel     = dbba_pkg::END_BLK;
                                n_state           = dbba_pkg::S_IDLE;
                            end
                        end else begin
                            o_cmd.addr_op = dbba_pkg::ADDR_BLK;
                            n_state       = dbba_pkg::S_CC_RD;
                        end
                    end
                    dbba_pkg::OP_IBEGIN: begin
                        if (i_sts.dirty) begin
                            o_cmd.addr_op = dbba_pkg::ADDR_ZERO;
                            n_state       = dbba_pkg::S_DROP_RD;
                        end else begin
                            o_cmd.flag_op = dbba_pkg::FLG_CLEAR;
                            n_state       = dbba_pkg::S_IDX;
                        end
                    end
                    dbba_pkg::OP_IDATA: begin
                        if (!i_sts.open) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = dbba_pkg::ST_INDEX;
                                n_state           = dbba_pkg::S_IDLE;
                            end
                        end else if (i_sts.failed || i_sts.blk_oob) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = i_sts.failed ? dbba_pkg::ST_TAKEN
                                                                 : dbba_pkg::ST_EXCEEDS;
                                if (!i_sts.last) begin
                                    o_cmd.flag_op = dbba_pkg::FLG_FAIL;
                                    n_state       = dbba_pkg::S_IDLE;
                                end else if (i_sts.dirty) begin
                                    o_cmd.addr_op = dbba_pkg::ADDR_ZERO;
                                    n_state       = dbba_pkg::S_DROP_RD;
                                end else begin
                                    o_cmd.flag_op = dbba_pkg::FLG_CLEAR;
                                    n_state       = dbba_pkg::S_IDLE;
                                end
                            end
                        end else begin
                            o_cmd.addr_op = dbba_pkg::ADDR_BLK;
                            n_state       = dbba_pkg::S_DATA_RD;
                        end
                    end
                    dbba_pkg::OP_LINK: begin
                        if (i_sts.link_exceeds) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = dbba_pkg::ST_EXCEEDS;
                                n_state           = dbba_pkg::S_IDLE;
                            end
                        end else begin
                            o_cmd.addr_op = dbba_pkg::ADDR_BLK;
                            n_state       = dbba_pkg::S_LS_RD;
                        end
                    end
                    dbba_pkg::OP_CLEAR: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = dbba_pkg::ST_OK;
                            o_cmd.bn_sel      = dbba_pkg::BN_ZERO;
                            o_cmd.addr_op     = dbba_pkg::ADDR_ZERO;
                            n_state           = dbba_pkg::S_CLR;
                        end
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = dbba_pkg::ST_OK;
                            o_cmd.bn_sel      = dbba_pkg::BN_ZERO;
                            n_state           = dbba_pkg::S_IDLE;
                        end
                    end
                endcase
            end

            // Drop sweep: clear every pending bit, keep the allocated bits.
            dbba_pkg::S_DROP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_DROP_WR;
            end
            dbba_pkg::S_DROP_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_mode = dbba_pkg::WR_DROP;
                if (i_sts.scan_end) begin
                    o_cmd.flag_op = dbba_pkg::FLG_CLEAR;
                    n_state       = (i_sts.op == dbba_pkg::OP_IBEGIN) ? dbba_pkg::S_IDX
                                                                    : dbba_pkg::S_IDLE;
                end else begin
                    o_cmd.addr_op = dbba_pkg::ADDR_INC;
                    n_state       = dbba_pkg::S_DROP_RD;
                end
            end

            // Commit sweep: fold pending bits into the allocated bits.
            dbba_pkg::S_COMMIT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_COMMIT_WR;
            end
            dbba_pkg::S_COMMIT_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_mode = dbba_pkg::WR_COMMIT;
                if (i_sts.scan_end) begin
                    o_cmd.flag_op = dbba_pkg::FLG_CLEAR;
                    n_state       = dbba_pkg::S_IDLE;
                end else begin
                    o_cmd.addr_op = dbba_pkg::ADDR_INC;
                    n_state       = dbba_pkg::S_COMMIT_RD;
                end
            end

            dbba_pkg::S_IDX: begin
                if (i_sts.blk_oob) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = dbba_pkg::ST_EXCEEDS;
                        o_cmd.flag_op     = dbba_pkg::FLG_BEGIN_FAIL;
                        n_state           = dbba_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.addr_op = dbba_pkg::ADDR_BLK;
                    n_state       = dbba_pkg::S_IDX_RD;
                end
            end
            dbba_pkg::S_IDX_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_IDX_CHK;
            end
            dbba_pkg::S_IDX_CHK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = dbba_pkg::S_IDLE;
                    if (i_sts.rd_alloc) begin
                        o_cmd.emit_status = dbba_pkg::ST_INDEX;
                        o_cmd.flag_op     = dbba_pkg::FLG_BEGIN_FAIL;
                    end else if (i_sts.last) begin
                        // Index block alone commits at once.
                        o_cmd.wr          = 1'b1;
                        o_cmd.wr_mode     = dbba_pkg::WR_SET_ALLOC;
                        o_cmd.emit_status = dbba_pkg::ST_OK;
                    end else begin
                        o_cmd.wr          = 1'b1;
                        o_cmd.wr_mode     = dbba_pkg::WR_SET_PEND;
                        o_cmd.flag_op     = dbba_pkg::FLG_BEGIN_OK;
                        o_cmd.emit_status = dbba_pkg::ST_PENDING;
                    end
                end
            end

            dbba_pkg::S_DATA_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_DATA_CHK;
            end
            dbba_pkg::S_DATA_CHK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.rd_alloc) begin
                        o_cmd.emit_status = dbba_pkg::ST_TAKEN;
                        if (i_sts.last) begin
                            // Open non-failed batch always holds its index block.
                            o_cmd.addr_op = dbba_pkg::ADDR_ZERO;
                            n_state       = dbba_pkg::S_DROP_RD;
                        end else begin
                            o_cmd.flag_op = dbba_pkg::FLG_FAIL;
                            n_state       = dbba_pkg::S_IDLE;
                        end
                    end else if (i_sts.last) begin
                        o_cmd.wr          = 1'b1;
                        o_cmd.wr_mode     = dbba_pkg::WR_SET_ALLOC;
                        o_cmd.emit_status = dbba_pkg::ST_OK;
                        o_cmd.addr_op     = dbba_pkg::ADDR_ZERO;
                        n_state           = dbba_pkg::S_COMMIT_RD;
                    end else begin
                        o_cmd.wr          = 1'b1;
                        o_cmd.wr_mode     = dbba_pkg::WR_SET_PEND;
                        o_cmd.emit_status = dbba_pkg::ST_PENDING;
                        n_state           = dbba_pkg::S_IDLE;
                    end
                end
            end

            // Contiguous check pass over the requested range.
            dbba_pkg::S_CC_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_CC_CHK;
            end
            dbba_pkg::S_CC_CHK: begin
                if (i_sts.rd_alloc) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = dbba_pkg::ST_TAKEN;
                        o_cmd.bn_sel      = dbba_pkg::BN_ADDR;
                        n_state           = dbba_pkg::S_IDLE;
                    end
                end else if (i_sts.cont_end) begin
                    o_cmd.addr_op = dbba_pkg::ADDR_BLK;
                    n_state       = dbba_pkg::S_CM_RD;
                end else begin
                    o_cmd.addr_op = dbba_pkg::ADDR_INC;
                    n_state       = dbba_pkg::S_CC_RD;
                end
            end

            // Contiguous mark pass.
            dbba_pkg::S_CM_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_CM_WR;
            end
            dbba_pkg::S_CM_WR: begin
                if (i_sts.cont_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.wr          = 1'b1;
                        o_cmd.wr_mode     = dbba_pkg::WR_SET_ALLOC;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = dbba_pkg::ST_OK;
                        o_cmd.end_sel     = dbba_pkg::END_CEND;
                        n_state           = dbba_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.wr      = 1'b1;
                    o_cmd.wr_mode = dbba_pkg::WR_SET_ALLOC;
                    o_cmd.addr_op = dbba_pkg::ADDR_INC;
                    n_state       = dbba_pkg::S_CM_RD;
                end
            end

            // Linked start block check.
            dbba_pkg::S_LS_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_LS_CHK;
            end
            dbba_pkg::S_LS_CHK: begin
                if (i_sts.rd_alloc || i_sts.cnt_zero) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = i_sts.rd_alloc ? dbba_pkg::ST_TAKEN
                                                           : dbba_pkg::ST_OK;
                        n_state           = dbba_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.addr_op   = dbba_pkg::ADDR_ZERO;
                    o_cmd.found_clr = 1'b1;
                    n_state         = dbba_pkg::S_LC_RD;
                end
            end

            // Linked count pass: enough free blocks?
            dbba_pkg::S_LC_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_LC_CHK;
            end
            dbba_pkg::S_LC_CHK: begin
                if (!i_sts.rd_alloc && i_sts.found_hit) begin
                    o_cmd.addr_op   = dbba_pkg::ADDR_ZERO;
                    o_cmd.found_clr = 1'b1;
                    n_state         = dbba_pkg::S_LA_RD;
                end else if (i_sts.scan_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = dbba_pkg::ST_FEW;
                        n_state           = dbba_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.found_inc = !i_sts.rd_alloc;
                    o_cmd.addr_op   = dbba_pkg::ADDR_INC;
                    n_state         = dbba_pkg::S_LC_RD;
                end
            end

            // Linked claim pass: one beat per claimed block.
            dbba_pkg::S_LA_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = dbba_pkg::S_LA_CHK;
            end
            dbba_pkg::S_LA_CHK: begin
                if (i_sts.rd_alloc) begin
                    o_cmd.addr_op = dbba_pkg::ADDR_INC;
                    n_state       = dbba_pkg::S_LA_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.wr          = 1'b1;
                    o_cmd.wr_mode     = dbba_pkg::WR_SET_ALLOC;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = dbba_pkg::ST_OK;
                    o_cmd.bn_sel      = dbba_pkg::BN_ADDR;
                    o_cmd.emit_last   = i_sts.found_hit;
                    if (i_sts.found_hit) begin
                        n_state = dbba_pkg::S_IDLE;
                    end else begin
                        o_cmd.found_inc = 1'b1;
                        o_cmd.addr_op   = dbba_pkg::ADDR_INC;
                        n_state         = dbba_pkg::S_LA_RD;
                    end
                end
            end

            default: begin
                n_state = dbba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/disk_block_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the disk block bitmap allocator.
// Depends on dbba_pkg, dbba_ctrl, dbba_dp (which holds the dbba_ram map).
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one command
//   beat: contiguous, indexed begin, indexed data, linked or clear. Output
//   channel (o_out_valid / i_out_ready / o_out_data) returns result beats;
//   the final beat of each command has last_result set. Only linked
//   allocation returns more than one beat (one per claimed block).
// Sequencing
//   One command is in flight at a time. Every walk over the map goes
//   through the one read port of the block map RAM: a contiguous check
//   and mark, a linked request, and a batch commit or drop after the
//   triggering beat. A clear sweeps the map after its result beat.
// Reset
//   After reset the block sweeps the map free with o_in_ready low,
//   then opens for commands.
// Back-pressure
//   One output register parts the channels; while it holds an untaken beat
//   the walk stalls at the next beat it must send, and nothing is lost.
module disk_block_bitmap_allocator_top #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dbba_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dbba_pkg::t_out o_out_data
);
    dbba_pkg::t_dp_cmd w_cmd;
    dbba_pkg::t_dp_sts w_sts;

    // Sequence each command.
    dbba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Hold the map, the batch flags and the output beat.
    dbba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/dbba_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the disk block bitmap allocator, bound to the top level.
// Depends on dbba_pkg and disk_block_bitmap_allocator_top.
module dbba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input dbba_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dbba_pkg::t_out o_out_data
);
    // Map clearing follows reset: no command taken right after it.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // One command at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready in cycle after accepted beat");

    // A stalled beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output beat changed while stalled");

    // When idle, any waiting beat closes its command.
    a_idle_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && o_out_valid) |-> o_out_data.last_result)
        else $error("ready for new command with non-final beat waiting");

endmodule

bind disk_block_bitmap_allocator_top dbba_checker u_checker (.*);

// ----- sim/dbba_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the disk block bitmap allocator testbench.
// Depends on dbba_pkg; keeps its own block map and compares every output beat.
module dbba_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  dbba_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  dbba_pkg::t_out i_out_data,
    output int             o_mismatches,
    output int             o_pending
);
    localparam int NBLK = 64;

    logic [NBLK-1:0] used_map;
    logic [NBLK-1:0] held_map;
    logic            batch_live;
    logic            batch_bad;
    dbba_pkg::t_out  due_results[$];

    function automatic dbba_pkg::t_out result_beat(dbba_pkg::t_status st, int bn, int eb,
                                                   logic lr);
        dbba_pkg::t_out r;
        r.status       = st;
        r.block_number = dbba_pkg::BLK_W'(bn);
        r.end_block    = dbba_pkg::BLK_W'(eb);
        r.last_result  = lr;
        return r;
    endfunction

    // Update the block map for one command beat and queue the beats it owes.
    task automatic apply_command(input dbba_pkg::t_in c);
        int blk;
        int cnt;
        int i;
        int first_hit;
        int claimed;
        blk = int'(c.block);
        cnt = int'(c.count);
        case (c.opcode)
            dbba_pkg::OP_CONT: begin
                if (blk + cnt > NBLK) begin
                    due_results.push_back(result_beat(dbba_pkg::ST_EXCEEDS, blk, 0, 1'b1));
                end else begin
                    first_hit = -1;
                    for (i = blk; i < blk + cnt; i++)
                        if (used_map[i] && first_hit < 0) first_hit = i;
                    if (first_hit >= 0) begin
                        due_results.push_back(result_beat(dbba_pkg::ST_TAKEN, first_hit,
                                                          0, 1'b1));
                    end else begin
                        for (i = blk; i < blk + cnt; i++) used_map[i] = 1'b1;
                        due_results.push_back(result_beat(dbba_pkg::ST_OK, blk,
                            (cnt == 0) ? blk : blk + cnt - 1, 1'b1));
                    end
                end
            end
            dbba_pkg::OP_IBEGIN: begin
                held_map   = '0;
                batch_live = 1'b0;
                batch_bad  = 1'b0;
                if (used_map[blk]) begin
                    // a failed batch stays open only to answer its data beats
                    batch_live = !c.last;
                    batch_bad  = !c.last;
                    due_results.push_back(result_beat(dbba_pkg::ST_INDEX, blk, 0, 1'b1));
                end else if (c.last) begin
                    used_map[blk] = 1'b1;
                    due_results.push_back(result_beat(dbba_pkg::ST_OK, blk, 0, 1'b1));
                end else begin
                    held_map[blk] = 1'b1;
                    batch_live    = 1'b1;
                    due_results.push_back(result_beat(dbba_pkg::ST_PENDING, blk, 0, 1'b1));
                end
            end
            dbba_pkg::OP_IDATA: begin
                if (!batch_live) begin
                    due_results.push_back(result_beat(dbba_pkg::ST_INDEX, blk, 0, 1'b1));
                end else if (batch_bad || used_map[blk]) begin
                    batch_bad = 1'b1;
                    due_results.push_back(result_beat(dbba_pkg::ST_TAKEN, blk, 0, 1'b1));
                    if (c.last) begin
                        held_map   = '0;
                        batch_live = 1'b0;
                        batch_bad  = 1'b0;
                    end
                end else begin
                    held_map[blk] = 1'b1;
                    if (c.last) begin
                        used_map   = used_map | held_map;
                        held_map   = '0;
                        batch_live = 1'b0;
                        due_results.push_back(result_beat(dbba_pkg::ST_OK, blk, 0, 1'b1));
                    end else begin
                        due_results.push_back(result_beat(dbba_pkg::ST_PENDING, blk,
                                                          0, 1'b1));
                    end
                end
            end
            dbba_pkg::OP_LINK: begin
                if (c.count > dbba_pkg::MAX_EMIT) begin
                    due_results.push_back(result_beat(dbba_pkg::ST_EXCEEDS, blk, 0, 1'b1));
                end else if (used_map[blk]) begin
                    due_results.push_back(result_beat(dbba_pkg::ST_TAKEN, blk, 0, 1'b1));
                end else if (cnt == 0) begin
                    due_results.push_back(result_beat(dbba_pkg::ST_OK, blk, 0, 1'b1));
                end else if ($countones(~used_map) < cnt) begin
                    due_results.push_back(result_beat(dbba_pkg::ST_FEW, blk, 0, 1'b1));
                end else begin
                    // claim the lowest free blocks, start block or not
                    claimed = 0;
                    for (i = 0; i < NBLK && claimed < cnt; i++) begin
                        if (!used_map[i]) begin
                            used_map[i] = 1'b1;
                            claimed++;
                            due_results.push_back(result_beat(dbba_pkg::ST_OK, i, 0,
                                                              claimed == cnt));
                        end
                    end
                end
            end
            dbba_pkg::OP_CLEAR: begin
                used_map   = '0;
                held_map   = '0;
                batch_live = 1'b0;
                batch_bad  = 1'b0;
                due_results.push_back(result_beat(dbba_pkg::ST_OK, 0, 0, 1'b1));
            end
            default: due_results.push_back(result_beat(dbba_pkg::ST_OK, 0, 0, 1'b1));
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        dbba_pkg::t_out want;
        if (!i_rst_n) begin
            used_map   = '0;
            held_map   = '0;
            batch_live = 1'b0;
            batch_bad  = 1'b0;
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) apply_command(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing due: %h", i_out_data);
                    o_mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                        o_mismatches++;
                    end
                    if (i_out_data.block_number !== want.block_number) begin
                        $error("block_number: expected %0d, got %0d",
                               want.block_number, i_out_data.block_number);
                        o_mismatches++;
                    end
                    if (i_out_data.end_block !== want.end_block) begin
                        $error("end_block: expected %0d, got %0d",
                               want.end_block, i_out_data.end_block);
                        o_mismatches++;
                    end
                    if (i_out_data.last_result !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, i_out_data.last_result);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ----- sim/disk_block_bitmap_allocator_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the disk block bitmap allocator: drives command beats,
// stalls the result channel and gives the verdict. Depends on dbba_pkg,
// dbba_result_checker and the allocator RTL.
module disk_block_bitmap_allocator_top_test;
    localparam int         ITEM_BUDGET  = 410;
    // Hard stop for a hung run; keep a wide margin over the slowest legal run.
    localparam int         CYCLE_LIMIT  = 5_000_000;
    // Covers a batch drop plus a clear sweep after the last beat.
    localparam int         DRAIN_CYCLES = 320;
    localparam logic [2:0] OP_UNDEF_LO  = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI  = 3'd7;

    typedef enum int {RX_STEADY, RX_COIN, RX_HOLD, RX_TOGGLE} t_rx_mode;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    dbba_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_ready  = 1'b0;
    dbba_pkg::t_out out_data;
    int             mismatches;
    int             pending;
    int             cycles     = 0;
    int             sent       = 0;
    int             burst_left = 0;
    int             rx_left    = 0;
    t_rx_mode       rx_mode    = RX_STEADY;

    disk_block_bitmap_allocator_top #(
        .NUM_BLOCKS(64)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    dbba_result_checker result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop: a hung handshake or a lost result beat ends up here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side back-pressure: pick a mode, hold it for a while, repeat.
    // Steady stretches run long so some phases see no stall at all.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_STEADY) ? $urandom_range(10, 60) : $urandom_range(1, 8);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_STEADY: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_HOLD:   out_ready <= 1'b0;
            default:   out_ready <= ~out_ready;
        endcase
    end

    function automatic dbba_pkg::t_in cmd(logic [2:0] op, int blk, int cnt, logic last);
        dbba_pkg::t_in c;
        c.opcode = op;
        c.block  = dbba_pkg::BLK_W'(blk);
        c.count  = dbba_pkg::CNT_W'(cnt);
        c.last   = last;
        return c;
    endfunction

    // Mostly short requests, some long ones, a few past the linked limit.
    function automatic int rand_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(0, 6);
        if (pick < 9) return $urandom_range(7, 64);
        return $urandom_range(65, 127);
    endfunction

    // Send one command beat. The sender runs in bursts: when a burst is
    // used up, drop valid for a random gap, then start a new burst. Hold
    // valid and the payload until the beat is taken.
    task automatic send_cmd(input dbba_pkg::t_in c);
        @(negedge clk);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!in_ready);
        burst_left = burst_left - 1;
        sent = sent + 1;
    endtask

    initial begin
        int   pick;
        int   n_data;
        int   k;
        logic close_it;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, every opcode, the corner cases.
        send_cmd(cmd(dbba_pkg::OP_CLEAR,  0,   0, 1'b0));
        send_cmd(cmd(dbba_pkg::OP_CONT,   0,   0, 1'b0));  // zero length, nothing marked
        send_cmd(cmd(dbba_pkg::OP_CONT,  63,   1, 1'b1));  // last block of the disk
        send_cmd(cmd(dbba_pkg::OP_CONT,  60,   5, 1'b0));  // runs off the end
        send_cmd(cmd(dbba_pkg::OP_CONT,  62,   2, 1'b0));  // hits block 63
        send_cmd(cmd(dbba_pkg::OP_CONT,  10,   4, 1'b0));
        send_cmd(cmd(dbba_pkg::OP_LINK,  20,   0, 1'b0));  // zero count, one ok beat
        send_cmd(cmd(dbba_pkg::OP_LINK,  63,   3, 1'b0));  // start already taken
        send_cmd(cmd(dbba_pkg::OP_LINK,   0, 127, 1'b1));  // above the emit limit
        send_cmd(cmd(dbba_pkg::OP_LINK,   5,   3, 1'b0));  // claims 0..2, not the start
        send_cmd(cmd(dbba_pkg::OP_IBEGIN, 30,  0, 1'b0));
        send_cmd(cmd(dbba_pkg::OP_IDATA,  12,  0, 1'b0));  // taken, batch goes bad
        send_cmd(cmd(dbba_pkg::OP_IDATA,  33,  0, 1'b1));  // answered, batch closes
        send_cmd(cmd(dbba_pkg::OP_IDATA,  34,  0, 1'b1));  // no batch open
        send_cmd(cmd(dbba_pkg::OP_IBEGIN, 10,  0, 1'b0));  // index taken, opens failed
        send_cmd(cmd(dbba_pkg::OP_IDATA,  40,  0, 1'b1));
        send_cmd(cmd(dbba_pkg::OP_IBEGIN, 40,  0, 1'b0));
        send_cmd(cmd(dbba_pkg::OP_IBEGIN, 45,  0, 1'b0));  // drops the open batch
        send_cmd(cmd(dbba_pkg::OP_CONT,   47,  2, 1'b0));  // served mid batch
        send_cmd(cmd(dbba_pkg::OP_IDATA,  48,  0, 1'b1));  // taken by the run above, batch dropped
        send_cmd(cmd(dbba_pkg::OP_IBEGIN, 50,  0, 1'b1));  // commits the index alone
        send_cmd(cmd(OP_UNDEF_HI, 63, 127, 1'b1));
        send_cmd(cmd(dbba_pkg::OP_CONT,    0,  64, 1'b0)); // whole disk, block 0 taken
        send_cmd(cmd(dbba_pkg::OP_LINK,    3,  60, 1'b0)); // too few free
        send_cmd(cmd(dbba_pkg::OP_CLEAR,  63, 127, 1'b1));
        send_cmd(cmd(dbba_pkg::OP_LINK,    0,  64, 1'b0)); // one beat per block
        send_cmd(cmd(dbba_pkg::OP_CLEAR,   0,   0, 1'b0));
        send_cmd(cmd(dbba_pkg::OP_CONT,    0,  64, 1'b0)); // whole disk at once

        // Random part: mostly well formed batches and requests, some noise.
        while (sent < ITEM_BUDGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_cmd(cmd(dbba_pkg::OP_CLEAR, $urandom_range(0, 63), rand_count(),
                             1'($urandom_range(0, 1))));
            end else if (pick < 28) begin
                send_cmd(cmd(dbba_pkg::OP_CONT, $urandom_range(0, 63), rand_count(),
                             1'($urandom_range(0, 1))));
            end else if (pick < 45) begin
                send_cmd(cmd(dbba_pkg::OP_LINK, $urandom_range(0, 63), rand_count(),
                             1'($urandom_range(0, 1))));
            end else if (pick < 88) begin
                // Open a batch, feed it data beats, usually close it on the
                // final one; now and then leave it open for the next command.
                n_data   = $urandom_range(0, 5);
                close_it = ($urandom_range(0, 9) != 0);
                send_cmd(cmd(dbba_pkg::OP_IBEGIN, $urandom_range(0, 63), rand_count(),
                             close_it && n_data == 0));
                for (k = 1; k <= n_data; k++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_cmd(cmd(dbba_pkg::OP_CLEAR, 0, 0, 1'b0));
                    else if ($urandom_range(0, 7) == 0)
                        send_cmd(cmd(dbba_pkg::OP_CONT, $urandom_range(0, 63),
                                     $urandom_range(0, 3), 1'b0));
                    send_cmd(cmd(dbba_pkg::OP_IDATA, $urandom_range(0, 63), rand_count(),
                                 close_it && k == n_data));
                end
            end else if (pick < 95) begin
                // stray data beat, usually with no batch behind it
                send_cmd(cmd(dbba_pkg::OP_IDATA, $urandom_range(0, 63), rand_count(),
                             1'($urandom_range(0, 1))));
            end else begin
                send_cmd(cmd(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)),
                             $urandom_range(0, 63), $urandom_range(0, 127),
                             1'($urandom_range(0, 1))));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        // Wait out every owed beat, then let any trailing sweep finish so a
        // stray extra beat still gets caught.
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
